/* rtl/mfs_pkg.sv */
package mfs_pkg;

    localparam int MODE_W   = 2;
    localparam int POS_W    = 19;
    localparam int VEL_W    = 11;
    localparam int RAD_W    = 8;
    localparam int PIX_W    = 10;
    localparam int SIZE_W   = 10;
    localparam int COLOR_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 40;

    localparam int DIFF_W = 20;
    localparam int MAG_W  = 19;
    localparam int D2_W   = 2 * MAG_W + 1;
    localparam int QBITS  = 17;
    localparam int NUM_W  = 2 * RAD_W + 32;
    localparam int DSH_W  = D2_W + QBITS;
    localparam int SUM_W  = 22;
    localparam int T_W    = 9;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHADE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_OUTSIDE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_INSIDE  = 2'd3;

    localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH   = 10'd500;
    localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT  = 10'd400;
    localparam logic [COLOR_W-1:0] RST_COLOR_OUTSIDE = 24'hD4195D;
    localparam logic [COLOR_W-1:0] RST_COLOR_INSIDE  = 24'h73D419;

    localparam logic [SUM_W-1:0] Q16_ONE  = 22'd65536;
    localparam logic [T_W-1:0]   T_FULL   = 9'd256;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MOVE  = 7'b0000010,
        ST_SETUP = 7'b0000100,
        ST_MULX  = 7'b0001000,
        ST_MULY  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

endpackage

/* rtl/metaball_field_shader_unit.sv */
// Channel   Direction  Handshake                 Payload
// s (in)    input      i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser (mode)
// m (out)   output     o_m_tvalid / i_m_tready   o_m_tdata
// cfg       input      i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// A load is written in the idle state; a move updates each blob in turn, x axis then y axis.
// A shade runs, for each enabled blob, a setup, two squaring passes on the
// shared multiplier and up to 18 restoring divide steps; a disabled blob gets only its
// setup pass, and a done state then waits for the output register to be free.
// Reset is synchronous; it clears the blob table and loads the config registers with their reset values.
// The output register lets the next transaction in while a result waits.
module metaball_field_shader_unit #(
    parameter int BLOB_COUNT = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // blob_index, load_x, load_y, load_dx, load_dy, load_radius, pixel_x, pixel_y
    input  logic [mfs_pkg::IN_DATA_W-1:0] i_s_tdata,
    // mode
    input  logic [mfs_pkg::MODE_W-1:0]    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // red, green, blue, blend_weight
    output logic [mfs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [mfs_pkg::COLOR_W-1:0]   i_cfg_wdata
);
    import mfs_pkg::*;

    localparam int IW = (BLOB_COUNT > 1) ? $clog2(BLOB_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(BLOB_COUNT - 1);

    logic [POS_W-1:0] r_px [BLOB_COUNT];
    logic [POS_W-1:0] r_py [BLOB_COUNT];
    logic [VEL_W-1:0] r_vx [BLOB_COUNT];
    logic [VEL_W-1:0] r_vy [BLOB_COUNT];
    logic [RAD_W-1:0] r_rad [BLOB_COUNT];

    logic [SIZE_W-1:0]  r_fw, r_fh;
    logic [COLOR_W-1:0] r_co, r_ci;

    t_state r_state, n_state;
    logic [IW-1:0]    r_idx;
    logic             r_axis;
    logic [4:0]       r_k;
    logic [PIX_W-1:0] r_pix_x, r_pix_y;
    logic [MAG_W-1:0] r_ax, r_ay;
    logic [D2_W-1:0]  r_d2;
    logic [NUM_W-1:0] r_rem;
    logic [DSH_W-1:0] r_dsh;
    logic [SUM_W-1:0] r_sum;
    logic             r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic [3:0]       in_idx;
    logic [RAD_W-1:0] cur_r;
    logic             last_blob;

    assign in_idx    = i_s_tdata[3:0];
    assign cur_r     = r_rad[r_idx];
    assign last_blob = (r_idx == LAST);

    // Move path for one axis.
    logic [POS_W-1:0]  mv_pos;
    logic [VEL_W-1:0]  mv_vel;
    logic [SIZE_W-1:0] mv_size;
    logic [8:0]        mv_half;
    logic signed [DIFF_W-1:0] mv_s;
    logic signed [21:0] mv_gap;
    logic [21:0]        mv_gap_abs;
    logic signed [9:0]  mv_hr;
    logic signed [21:0] mv_lim;
    logic               mv_flip;

    always_comb begin
        mv_pos     = r_axis ? r_py[r_idx] : r_px[r_idx];
        mv_vel     = r_axis ? r_vy[r_idx] : r_vx[r_idx];
        mv_size    = r_axis ? r_fh : r_fw;
        mv_half    = mv_size[SIZE_W-1:1];
        mv_s       = DIFF_W'($signed(mv_pos)) + DIFF_W'($signed(mv_vel));
        mv_gap     = $signed({5'd0, mv_half, 8'd0}) - 22'(mv_s);
        mv_gap_abs = mv_gap[21] ? 22'(-mv_gap) : mv_gap;
        mv_hr      = $signed({1'b0, mv_half}) - $signed({2'b0, cur_r});
        mv_lim     = {{4{mv_hr[9]}}, mv_hr, 8'd0};
        mv_flip    = $signed(mv_gap_abs) > mv_lim;
    end

    // Shade setup and shared arithmetic.
    logic signed [DIFF_W-1:0] sd_x, sd_y;
    logic [MAG_W-1:0]  sd_ax, sd_ay;
    logic [MAG_W-1:0]  mul_a;
    logic [2*MAG_W-1:0] mul_p;
    logic [D2_W-1:0]   d2_full;
    logic              div_hit;
    logic [NUM_W-1:0]  div_sub;

    always_comb begin
        sd_x  = $signed({2'b0, r_pix_x, 8'd0}) - DIFF_W'($signed(r_px[r_idx]));
        sd_y  = $signed({2'b0, r_pix_y, 8'd0}) - DIFF_W'($signed(r_py[r_idx]));
        sd_ax = sd_x[DIFF_W-1] ? MAG_W'(-sd_x) : MAG_W'(sd_x);
        sd_ay = sd_y[DIFF_W-1] ? MAG_W'(-sd_y) : MAG_W'(sd_y);
        mul_a = (r_state == ST_MULY) ? r_ay : r_ax;
        mul_p = (2*MAG_W)'(mul_a) * (2*MAG_W)'(mul_a);
        d2_full = r_d2 + D2_W'(mul_p);
        div_hit = {{(DSH_W-NUM_W){1'b0}}, r_rem} >= r_dsh;
        div_sub = r_rem - NUM_W'(r_dsh);
    end

    // Final blend.
    logic [SUM_W-1:0] fin_e;
    logic [T_W-1:0]   fin_t;
    logic [T_W-1:0]   fin_tn;
    logic [16:0]      fin_r, fin_g, fin_b;

    always_comb begin
        fin_e = (r_sum - Q16_ONE) >> 8;
        if (r_sum <= Q16_ONE) begin
            fin_t = '0;
        end else if (fin_e > SUM_W'(T_FULL)) begin
            fin_t = T_FULL;
        end else begin
            fin_t = fin_e[T_W-1:0];
        end
        fin_tn = T_FULL - fin_t;
        fin_r = 17'(r_co[23:16]) * 17'(fin_tn) + 17'(r_ci[23:16]) * 17'(fin_t);
        fin_g = 17'(r_co[15:8]) * 17'(fin_tn) + 17'(r_ci[15:8]) * 17'(fin_t);
        fin_b = 17'(r_co[7:0]) * 17'(fin_tn) + 17'(r_ci[7:0]) * 17'(fin_t);
    end

    logic out_free;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == MODE_MOVE) begin
                        n_state = ST_MOVE;
                    end else if (i_s_tuser == MODE_SHADE) begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_MOVE: begin
                if (r_axis && last_blob) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SETUP: begin
                if (cur_r != '0) begin
                    n_state = ST_MULX;
                end else if (last_blob) begin
                    n_state = ST_DONE;
                end
            end
            ST_MULX: n_state = ST_MULY;
            ST_MULY: n_state = ST_DIV;
            ST_DIV: begin
                if ((div_hit && r_k == 5'(QBITS)) || r_k == '0) begin
                    n_state = last_blob ? ST_DONE : ST_SETUP;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_fw        <= RST_FRAME_WIDTH;
            r_fh        <= RST_FRAME_HEIGHT;
            r_co        <= RST_COLOR_OUTSIDE;
            r_ci        <= RST_COLOR_INSIDE;
            r_idx       <= '0;
            r_axis      <= 1'b0;
            for (int i = 0; i < BLOB_COUNT; i++) begin
                r_px[i]  <= '0;
                r_py[i]  <= '0;
                r_vx[i]  <= '0;
                r_vy[i]  <= '0;
                r_rad[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_FRAME_WIDTH:   r_fw <= i_cfg_wdata[SIZE_W-1:0];
                    REG_FRAME_HEIGHT:  r_fh <= i_cfg_wdata[SIZE_W-1:0];
                    REG_COLOR_OUTSIDE: r_co <= i_cfg_wdata;
                    REG_COLOR_INSIDE:  r_ci <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_idx  <= '0;
                    r_axis <= 1'b0;
                    r_sum  <= '0;
                    r_pix_x <= i_s_tdata[81:72];
                    r_pix_y <= i_s_tdata[91:82];
                    if (i_s_tvalid && i_s_tuser == MODE_LOAD
                            && {1'b0, in_idx} < 5'(BLOB_COUNT)) begin
                        r_px[IW'(in_idx)]  <= i_s_tdata[22:4];
                        r_py[IW'(in_idx)]  <= i_s_tdata[41:23];
                        r_vx[IW'(in_idx)]  <= i_s_tdata[52:42];
                        r_vy[IW'(in_idx)]  <= i_s_tdata[63:53];
                        r_rad[IW'(in_idx)] <= i_s_tdata[71:64];
                    end
                end
                ST_MOVE: begin
                    if (r_axis) begin
                        r_py[r_idx] <= mv_s[POS_W-1:0];
                        if (mv_flip) begin
                            r_vy[r_idx] <= -mv_vel;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_px[r_idx] <= mv_s[POS_W-1:0];
                        if (mv_flip) begin
                            r_vx[r_idx] <= -mv_vel;
                        end
                    end
                    r_axis <= !r_axis;
                end
                ST_SETUP: begin
                    r_ax  <= sd_ax;
                    r_ay  <= sd_ay;
                    r_d2  <= '0;
                    r_rem <= {(2*RAD_W)'(cur_r) * (2*RAD_W)'(cur_r), 32'd0};
                    r_k   <= 5'(QBITS);
                    if (cur_r == '0) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_MULX: begin
                    r_d2 <= D2_W'(mul_p);
                end
                ST_MULY: begin
                    r_dsh <= {d2_full, {QBITS{1'b0}}};
                end
                ST_DIV: begin
                    if (div_hit) begin
                        r_rem <= div_sub;
                        r_sum <= r_sum + (SUM_W'(1) << r_k);
                    end
                    r_dsh <= r_dsh >> 1;
                    r_k   <= r_k - 1'b1;
                    if ((div_hit && r_k == 5'(QBITS)) || r_k == '0) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= {7'd0, fin_t, fin_b[15:8], fin_g[15:8], fin_r[15:8]};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* tb/metaball_field_shader_unit_tb.sv */
`timescale 1ns / 1ps

module metaball_field_shader_unit_tb;
    import mfs_pkg::*;

    localparam int NBLOBS = 10;
    localparam int SETTLE = 300;

    typedef struct packed {
        logic [8:0] weight;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;
    logic [MODE_W-1:0]      i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [COLOR_W-1:0]     i_cfg_wdata;

    logic signed [POS_W-1:0] ball_x [NBLOBS];
    logic signed [POS_W-1:0] ball_y [NBLOBS];
    logic signed [VEL_W-1:0] ball_vx [NBLOBS];
    logic signed [VEL_W-1:0] ball_vy [NBLOBS];
    logic [RAD_W-1:0]        ball_r [NBLOBS];
    logic [SIZE_W-1:0]       width_reg;
    logic [SIZE_W-1:0]       height_reg;
    logic [COLOR_W-1:0]      outside_reg;
    logic [COLOR_W-1:0]      inside_reg;

    pixel_t pixel_queue[$];
    int     error_count;
    int     ready_style;

    metaball_field_shader_unit #(.BLOB_COUNT(NBLOBS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(input logic [3:0] idx,
            input logic [18:0] x, input logic [18:0] y, input logic [10:0] vx,
            input logic [10:0] vy, input logic [7:0] r, input logic [9:0] px,
            input logic [9:0] py);
        return {4'd0, py, px, r, vy, vx, y, x, idx};
    endfunction

    function automatic void bounce_axis(input logic signed [POS_W-1:0] p,
            input logic signed [VEL_W-1:0] v, input logic [RAD_W-1:0] r,
            input logic [SIZE_W-1:0] size, output logic signed [POS_W-1:0] np,
            output logic signed [VEL_W-1:0] nv);
        longint half;
        longint s;
        longint gap;
        half = longint'(size >> 1);
        s = longint'(p) + longint'(v);
        gap = half * 256 - s;
        if (gap < 0) gap = -gap;
        nv = v;
        if (gap > (half - longint'(r)) * 256) nv = -v;
        np = s[POS_W-1:0];
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
            input logic [8:0] t);
        int unsigned acc;
        acc = a * (256 - t) + b * t;
        return acc[15:8];
    endfunction

    function automatic void apply_item(input logic [MODE_W-1:0] mode,
            input logic [IN_DATA_W-1:0] d);
        logic [3:0] idx;
        longint px;
        longint py;
        longint ax;
        longint ay;
        longint unsigned d2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned rr;
        logic [8:0] t;
        pixel_t res;
        idx = d[3:0];
        if (mode == MODE_LOAD) begin
            if (idx < NBLOBS) begin
                ball_x[idx] = d[22:4];
                ball_y[idx] = d[41:23];
                ball_vx[idx] = d[52:42];
                ball_vy[idx] = d[63:53];
                ball_r[idx] = d[71:64];
            end
        end else if (mode == MODE_MOVE) begin
            for (int i = 0; i < NBLOBS; i++) begin
                bounce_axis(ball_x[i], ball_vx[i], ball_r[i], width_reg, ball_x[i], ball_vx[i]);
                bounce_axis(ball_y[i], ball_vy[i], ball_r[i], height_reg, ball_y[i],
                            ball_vy[i]);
            end
        end else if (mode == MODE_SHADE) begin
            px = longint'(d[81:72]) * 256;
            py = longint'(d[91:82]) * 256;
            sum = 0;
            for (int i = 0; i < NBLOBS; i++) begin
                if (ball_r[i] != 0) begin
                    ax = px - longint'(ball_x[i]);
                    ay = py - longint'(ball_y[i]);
                    if (ax < 0) ax = -ax;
                    if (ay < 0) ay = -ay;
                    d2 = ax * ax + ay * ay;
                    rr = longint'(ball_r[i]) * longint'(ball_r[i]);
                    if (d2 == 0) begin
                        term = 131072;
                    end else begin
                        term = (rr << 32) / d2;
                        if (term > 131072) term = 131072;
                    end
                    sum += term;
                end
            end
            if (sum <= 65536) t = 0;
            else if (((sum - 65536) >> 8) > 256) t = T_FULL;
            else t = 9'((sum - 65536) >> 8);
            res.red = mix_channel(outside_reg[23:16], inside_reg[23:16], t);
            res.green = mix_channel(outside_reg[15:8], inside_reg[15:8], t);
            res.blue = mix_channel(outside_reg[7:0], inside_reg[7:0], t);
            res.weight = t;
            pixel_queue.push_back(res);
        end
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IN_DATA_W-1:0] d);
        int gap;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        apply_item(mode, d);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [COLOR_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_FRAME_WIDTH: width_reg = v[SIZE_W-1:0];
            REG_FRAME_HEIGHT: height_reg = v[SIZE_W-1:0];
            REG_COLOR_OUTSIDE: outside_reg = v;
            REG_COLOR_INSIDE: inside_reg = v;
        endcase
    endtask

    task automatic set_all(input logic [9:0] w, input logic [9:0] h, input logic [23:0] co,
            input logic [23:0] ci);
        write_reg(REG_FRAME_WIDTH, 24'(w));
        write_reg(REG_FRAME_HEIGHT, 24'(h));
        write_reg(REG_COLOR_OUTSIDE, co);
        write_reg(REG_COLOR_INSIDE, ci);
    endtask

    task automatic shade_at(input logic [9:0] px, input logic [9:0] py);
        send_item(MODE_SHADE, pack_item(4'($urandom), 19'($urandom), 19'($urandom),
                  11'($urandom), 11'($urandom), 8'($urandom), px, py));
    endtask

    task automatic test_directed();
        send_item(MODE_SHADE, pack_item(0, 0, 0, 0, 0, 0, 10'd0, 10'd0));
        send_item(MODE_LOAD, pack_item(0, 19'sd25600, 19'sd12800, 11'sd5, -11'sd3, 8'd40,
                  0, 0));
        send_item(MODE_LOAD, pack_item(1, 19'h40000, 19'h3FFFF, 11'h400, 11'h3FF, 8'd255,
                  0, 0));
        send_item(MODE_LOAD, pack_item(2, 19'h3FFFF, 19'h40000, 11'h3FF, 11'h400, 8'd0,
                  0, 0));
        send_item(MODE_LOAD, pack_item(4'd15, 19'h7FFFF, 19'h7FFFF, 11'h7FF, 11'h7FF, 8'hFF,
                  10'h3FF, 10'h3FF));
        send_item(MODE_LOAD, pack_item(4'd10, 19'd0, 19'd0, 0, 0, 8'd200, 0, 0));
        send_item(MODE_NOP, {IN_DATA_W{1'b1}});
        shade_at(10'd100, 10'd50);
        shade_at(10'd110, 10'd50);
        shade_at(10'd0, 10'd0);
        shade_at(10'd1023, 10'd1023);
        send_item(MODE_MOVE, '0);
        send_item(MODE_MOVE, '0);
        shade_at(10'd100, 10'd50);
        send_item(MODE_LOAD, pack_item(3, 19'sd2560, 19'sd2560, 11'sd1023, -11'sd1024, 8'd3,
                  0, 0));
        shade_at(10'd10, 10'd10);
        send_item(MODE_LOAD, pack_item(1, 19'sd262000, -19'sd262100, 11'sd1023, -11'sd1024,
                  8'd1, 0, 0));
        send_item(MODE_MOVE, '0);
        shade_at(10'd10, 10'd10);
        shade_at(10'd1023, 10'd0);
        drain();
    endtask

    task automatic test_small_frame();
        set_all(10'd1, 10'd1, 24'h000000, 24'hFFFFFF);
        repeat (4) send_item(MODE_MOVE, '0);
        shade_at(10'd10, 10'd10);
        drain();
        set_all(10'd1023, 10'd1023, 24'hFFFFFF, 24'h000000);
        repeat (3) send_item(MODE_MOVE, '0);
        shade_at(10'd10, 10'd10);
        drain();
    endtask

    task automatic random_phase(input int count);
        int k;
        logic [3:0] idx;
        logic [9:0] px;
        logic [9:0] py;
        logic [18:0] bx;
        logic [18:0] by;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 30) begin
                idx = (k < 3) ? 4'($urandom) : 4'($urandom_range(0, NBLOBS - 1));
                if (k < 6) begin
                    bx = 19'($urandom);
                    by = 19'($urandom);
                end else begin
                    bx = 19'($urandom_range(0, width_reg * 256));
                    by = 19'($urandom_range(0, height_reg * 256));
                end
                send_item(MODE_LOAD, pack_item(idx, bx, by, 11'($urandom), 11'($urandom),
                          (k < 10) ? 8'($urandom) : 8'($urandom_range(0, 50)), 0, 0));
            end else if (k < 42) begin
                send_item(MODE_MOVE, 96'({$urandom, $urandom, $urandom}));
            end else if (k < 45) begin
                send_item(MODE_NOP, 96'({$urandom, $urandom, $urandom}));
            end else begin
                idx = 4'($urandom_range(0, NBLOBS - 1));
                if (k < 80 && ball_x[idx] >= 0 && ball_y[idx] >= 0) begin
                    px = 10'((ball_x[idx] >>> 8) + $urandom_range(0, 60) - 30);
                    py = 10'((ball_y[idx] >>> 8) + $urandom_range(0, 60) - 30);
                end else begin
                    px = 10'($urandom);
                    py = 10'($urandom);
                end
                shade_at(px, py);
            end
        end
        drain();
    endtask

    task automatic test_random();
        random_phase(250);
        set_all(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)), 24'($urandom),
                24'($urandom));
        ready_style = 1;
        random_phase(250);
        set_all(10'd1023, 10'd1, 24'hFFFFFF, 24'h000000);
        ready_style = 0;
        random_phase(150);
        set_all(10'd300, 10'd200, 24'($urandom), 24'($urandom));
        ready_style = 2;
        random_phase(250);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (ready_style == 2) begin
            i_m_tready <= 1'b1;
        end else if (ready_style == 1) begin
            i_m_tready <= ($urandom_range(0, 99) < 40);
        end else begin
            i_m_tready <= ($urandom_range(0, 99) < 85) || ($urandom_range(0, 99) < 3);
        end
    end

    always @(posedge i_clk) begin
        pixel_t got;
        pixel_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[32:0];
            if (pixel_queue.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h", $realtime, got);
                error_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (got.red !== want.red) begin
                    $display("%0t: red expected %0d actual %0d", $realtime, want.red, got.red);
                    error_count++;
                end
                if (got.green !== want.green) begin
                    $display("%0t: green expected %0d actual %0d", $realtime, want.green,
                             got.green);
                    error_count++;
                end
                if (got.blue !== want.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $realtime, want.blue,
                             got.blue);
                    error_count++;
                end
                if (got.weight !== want.weight) begin
                    $display("%0t: blend_weight expected %0d actual %0d", $realtime,
                             want.weight, got.weight);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count = 0;
        ready_style = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        width_reg = RST_FRAME_WIDTH;
        height_reg = RST_FRAME_HEIGHT;
        outside_reg = RST_COLOR_OUTSIDE;
        inside_reg = RST_COLOR_INSIDE;
        for (int i = 0; i < NBLOBS; i++) begin
            ball_x[i] = 0;
            ball_y[i] = 0;
            ball_vx[i] = 0;
            ball_vy[i] = 0;
            ball_r[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_small_frame();
        test_random();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
